[rtl/gbs_pkg.sv]
// ----------------------------------------------------------------------------
// gbs_pkg - shared types and constants for greedy box suppression
// Threshold reset value, widths and controller state encodings.
// ----------------------------------------------------------------------------
package gbs_pkg;

   localparam int MaxBoxesDefault   = 64;
   localparam int CoordWidthDefault = 16;
   localparam int ScoreWidth        = 16;
   localparam int ThrWidth          = 9;
   localparam logic [ThrWidth-1:0] ThrReset = 9'd154;

   typedef enum logic [2:0] {
      SORT_IDLE,
      SORT_READ,
      SORT_CMP,
      SORT_DONE
   } sort_state_type;

   typedef enum logic [2:0] {
      SUP_IDLE,
      SUP_PICK,
      SUP_EMIT,
      SUP_READ,
      SUP_MUL,
      SUP_CMP,
      SUP_DONE
   } sup_state_type;

endpackage

[rtl/gbs_front.sv]
// ----------------------------------------------------------------------------
// gbs_front - box intake and ranking
// Stores boxes of a set, then ranks them by descending score with a stable
// insertion sort (one compare per cycle). Hands a finished set to the back.
// ----------------------------------------------------------------------------
module gbs_front #(
   parameter int MAX_BOXES   = gbs_pkg::MaxBoxesDefault,
   parameter int COORD_WIDTH = gbs_pkg::CoordWidthDefault,
   localparam int IdxW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1,
   localparam int CntW = $clog2(MAX_BOXES + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [4*COORD_WIDTH-1:0]      in_corners,
   input  logic [gbs_pkg::ScoreWidth-1:0] in_score,
   input  logic                          in_last,
   output logic                          in_busy,
   // set handoff
   output logic                          set_valid,
   output logic [CntW-1:0]               set_count,
   output logic                          set_overflow,
   input  logic                          set_taken,
   // back side read ports
   input  logic [IdxW-1:0]               rank_addr,
   output logic [IdxW-1:0]               rank_data,
   input  logic [IdxW-1:0]               box_addr_a,
   output logic [4*COORD_WIDTH-1:0]      box_corner_a,
   output logic [gbs_pkg::ScoreWidth-1:0] box_score_a,
   input  logic [IdxW-1:0]               box_addr_b,
   output logic [4*COORD_WIDTH-1:0]      box_corner_b
);

   localparam int RankW = gbs_pkg::ScoreWidth + IdxW;

   logic [4*COORD_WIDTH-1:0]       corner_mem [MAX_BOXES];
   logic [gbs_pkg::ScoreWidth-1:0] score_mem  [MAX_BOXES];
   // rank entry is {score, box index}, so one read serves a compare
   logic [RankW-1:0]               rank_mem   [MAX_BOXES];

   gbs_pkg::sort_state_type state_ff, state_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            ovf_ff, ovf_in;
   logic [CntW-1:0] i_ff, i_in;
   logic [CntW-1:0] j_ff, j_in;
   logic [gbs_pkg::ScoreWidth-1:0] score_rd_ff;
   logic [RankW-1:0] rank_rd_ff;

   logic accept;
   logic shift;
   logic rank_we;
   logic [IdxW-1:0] rank_waddr;
   logic [RankW-1:0] rank_wdata;
   logic [IdxW-1:0] rank_raddr;

   assign accept  = in_valid && (state_ff == gbs_pkg::SORT_IDLE);
   assign in_busy = (state_ff != gbs_pkg::SORT_IDLE);

   // store writes
   always_ff @(posedge clock) begin
      if (accept && (count_ff < CntW'(MAX_BOXES))) begin
         corner_mem[count_ff[IdxW-1:0]] <= in_corners;
         score_mem[count_ff[IdxW-1:0]]  <= in_score;
      end
   end

   // score of box i is in score_rd_ff, rank[j-1] in rank_rd_ff during CMP
   assign shift = (j_ff != '0) && (rank_rd_ff[RankW-1:IdxW] < score_rd_ff);

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      ovf_in     = ovf_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      rank_we    = 1'b0;
      rank_waddr = j_ff[IdxW-1:0];
      rank_wdata = {score_rd_ff, i_ff[IdxW-1:0]};
      rank_raddr = j_ff[IdxW-1:0] - 1'b1;
      unique case (state_ff)
         gbs_pkg::SORT_IDLE: begin
            if (accept) begin
               if (count_ff < CntW'(MAX_BOXES)) begin
                  count_in = count_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               if (in_last) begin
                  i_in     = '0;
                  state_in = gbs_pkg::SORT_READ;
               end
            end
         end
         gbs_pkg::SORT_READ: begin
            rank_raddr = i_ff[IdxW-1:0] - 1'b1;
            if (i_ff == count_ff) begin
               state_in = gbs_pkg::SORT_DONE;
            end else begin
               j_in     = i_ff;
               state_in = gbs_pkg::SORT_CMP;
            end
         end
         gbs_pkg::SORT_CMP: begin
            rank_we = 1'b1;
            if (shift) begin
               // move rank[j-1] up, fetch the entry below it
               rank_wdata = rank_rd_ff;
               j_in       = j_ff - 1'b1;
               rank_raddr = j_ff[IdxW-1:0] - IdxW'(2);
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = gbs_pkg::SORT_READ;
            end
         end
         gbs_pkg::SORT_DONE: begin
            if (set_taken) begin
               count_in = '0;
               ovf_in   = 1'b0;
               state_in = gbs_pkg::SORT_IDLE;
            end
         end
         default: state_in = gbs_pkg::SORT_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gbs_pkg::SORT_IDLE;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         i_ff     <= '0;
         j_ff     <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rank_we) begin
         rank_mem[rank_waddr] <= rank_wdata;
      end
      score_rd_ff <= score_mem[i_ff[IdxW-1:0]];
      rank_rd_ff  <= rank_mem[rank_raddr];
   end

   assign set_valid    = (state_ff == gbs_pkg::SORT_DONE);
   assign set_count    = count_ff;
   assign set_overflow = ovf_ff;

   always_ff @(posedge clock) begin
      rank_data    <= rank_mem[rank_addr][IdxW-1:0];
      box_corner_a <= corner_mem[box_addr_a];
      box_score_a  <= score_mem[box_addr_a];
      box_corner_b <= corner_mem[box_addr_b];
   end

endmodule

[rtl/gbs_back.sv]
// ----------------------------------------------------------------------------
// gbs_back - suppression and emit
// Walks ranked boxes; each unsuppressed box is emitted and tested against
// every later unsuppressed box (staged multiplies).
// ----------------------------------------------------------------------------
module gbs_back #(
   parameter int MAX_BOXES   = gbs_pkg::MaxBoxesDefault,
   parameter int COORD_WIDTH = gbs_pkg::CoordWidthDefault,
   localparam int IdxW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1,
   localparam int CntW = $clog2(MAX_BOXES + 1),
   localparam int SpanW = COORD_WIDTH + 1,
   localparam int AreaW = 2 * SpanW,
   localparam int UniW  = AreaW + 1,
   localparam int CmpW  = UniW + gbs_pkg::ThrWidth
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [gbs_pkg::ThrWidth-1:0]  threshold,
   input  logic                          set_valid,
   input  logic [CntW-1:0]               set_count,
   input  logic                          set_overflow,
   output logic                          set_taken,
   output logic [IdxW-1:0]               rank_addr,
   input  logic [IdxW-1:0]               rank_data,
   output logic [IdxW-1:0]               box_addr_a,
   input  logic [4*COORD_WIDTH-1:0]      box_corner_a,
   input  logic [gbs_pkg::ScoreWidth-1:0] box_score_a,
   output logic [IdxW-1:0]               box_addr_b,
   input  logic [4*COORD_WIDTH-1:0]      box_corner_b,
   output logic                          out_valid,
   output logic [4*COORD_WIDTH-1:0]      out_corners,
   output logic [gbs_pkg::ScoreWidth-1:0] out_score,
   output logic                          out_last,
   output logic                          out_overflow
);

   gbs_pkg::sup_state_type state_ff, state_in;
   logic [MAX_BOXES-1:0] sup_ff, sup_in;
   logic [CntW-1:0] i_ff, i_in, j_ff, j_in;
   logic            have_ff, have_in;   // a pending kept box awaits its last flag
   logic [4*COORD_WIDTH-1:0] pend_c_ff, pend_c_in;
   logic [gbs_pkg::ScoreWidth-1:0] pend_s_ff, pend_s_in;
   logic [4*COORD_WIDTH-1:0] a_c_ff, a_c_in;
   logic [1:0] wait_ff, wait_in;

   // staged overlap test
   logic signed [COORD_WIDTH-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
   logic signed [COORD_WIDTH-1:0] ix0, iy0, ix1, iy1;
   logic [SpanW-1:0] iw_ff, ih_ff, aw_ff, ah_ff, bw_ff, bh_ff;
   logic [AreaW-1:0] inter_ff, area_a_ff, area_b_ff;
   logic [UniW-1:0]  uni;
   logic [CmpW-1:0]  lhs_ff, rhs_ff;

   function automatic logic [SpanW-1:0] span_f(input logic signed [COORD_WIDTH-1:0] lo,
                                               input logic signed [COORD_WIDTH-1:0] hi);
      logic signed [SpanW-1:0] d;
      d = SpanW'(hi) - SpanW'(lo);
      return (hi > lo) ? SpanW'(d) : '0;
   endfunction

   assign {ay1, ax1, ay0, ax0} = a_c_ff;
   assign {by1, bx1, by0, bx0} = box_corner_b;
   assign ix0 = (ax0 > bx0) ? ax0 : bx0;
   assign iy0 = (ay0 > by0) ? ay0 : by0;
   assign ix1 = (ax1 < bx1) ? ax1 : bx1;
   assign iy1 = (ay1 < by1) ? ay1 : by1;
   assign uni = UniW'(area_a_ff) + UniW'(area_b_ff) - UniW'(inter_ff);

   always_ff @(posedge clock) begin
      iw_ff <= span_f(ix0, ix1);
      ih_ff <= span_f(iy0, iy1);
      aw_ff <= span_f(ax0, ax1);
      ah_ff <= span_f(ay0, ay1);
      bw_ff <= span_f(bx0, bx1);
      bh_ff <= span_f(by0, by1);
      inter_ff  <= iw_ff * ih_ff;
      area_a_ff <= aw_ff * ah_ff;
      area_b_ff <= bw_ff * bh_ff;
      lhs_ff <= {CmpW'(inter_ff)} << 8;
      rhs_ff <= CmpW'(uni) * CmpW'(threshold);
   end

   always_comb begin
      state_in  = state_ff;
      sup_in    = sup_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      have_in   = have_ff;
      pend_c_in = pend_c_ff;
      pend_s_in = pend_s_ff;
      a_c_in    = a_c_ff;
      wait_in   = wait_ff;
      set_taken = 1'b0;
      out_valid = 1'b0;
      out_last  = 1'b0;
      rank_addr  = i_ff[IdxW-1:0];
      box_addr_a = rank_data;
      box_addr_b = rank_data;
      unique case (state_ff)
         gbs_pkg::SUP_IDLE: begin
            if (set_valid) begin
               sup_in  = '0;
               i_in    = '0;
               have_in = 1'b0;
               wait_in = '0;
               state_in = gbs_pkg::SUP_PICK;
            end
         end
         gbs_pkg::SUP_PICK: begin
            // wait cycles: rank read, then box read
            wait_in = wait_ff + 1'b1;
            if (i_ff == set_count) begin
               if (have_ff) out_valid = 1'b1;
               out_last  = 1'b1;
               set_taken = 1'b1;
               state_in  = gbs_pkg::SUP_IDLE;
            end else if (sup_ff[i_ff[IdxW-1:0]]) begin
               i_in = i_ff + 1'b1;
               wait_in = '0;
            end else if (wait_ff == 2'd2) begin
               a_c_in = box_corner_a;
               wait_in = '0;
               state_in = gbs_pkg::SUP_EMIT;
            end
         end
         gbs_pkg::SUP_EMIT: begin
            // previous kept box leaves now that a later one exists
            if (have_ff) out_valid = 1'b1;
            have_in   = 1'b1;
            pend_c_in = a_c_ff;
            pend_s_in = box_score_a;
            j_in = i_ff + 1'b1;
            state_in = gbs_pkg::SUP_READ;
         end
         gbs_pkg::SUP_READ: begin
            rank_addr = j_ff[IdxW-1:0];
            wait_in = wait_ff + 1'b1;
            if (j_ff == set_count) begin
               i_in = i_ff + 1'b1;
               wait_in = '0;
               state_in = gbs_pkg::SUP_PICK;
            end else if (sup_ff[j_ff[IdxW-1:0]]) begin
               j_in = j_ff + 1'b1;
               wait_in = '0;
            end else if (wait_ff == 2'd2) begin
               wait_in = '0;
               state_in = gbs_pkg::SUP_MUL;
            end
         end
         gbs_pkg::SUP_MUL: begin
            rank_addr = j_ff[IdxW-1:0];
            wait_in = wait_ff + 1'b1;
            if (wait_ff == 2'd3) begin
               wait_in = '0;
               state_in = gbs_pkg::SUP_CMP;
            end
         end
         gbs_pkg::SUP_CMP: begin
            rank_addr = j_ff[IdxW-1:0];
            if (lhs_ff > rhs_ff) sup_in[j_ff[IdxW-1:0]] = 1'b1;
            j_in = j_ff + 1'b1;
            state_in = gbs_pkg::SUP_READ;
         end
         default: state_in = gbs_pkg::SUP_IDLE;
      endcase
   end

   assign out_corners  = pend_c_ff;
   assign out_score    = pend_s_ff;
   assign out_overflow = set_overflow;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gbs_pkg::SUP_IDLE;
         sup_ff   <= '0;
         have_ff  <= 1'b0;
         wait_ff  <= '0;
      end else begin
         state_ff <= state_in;
         sup_ff   <= sup_in;
         have_ff  <= have_in;
         wait_ff  <= wait_in;
      end
      i_ff      <= i_in;
      j_ff      <= j_in;
      pend_c_ff <= pend_c_in;
      pend_s_ff <= pend_s_in;
      a_c_ff    <= a_c_in;
   end

endmodule

[rtl/greedy_box_suppression.sv]
// ----------------------------------------------------------------------------
// greedy_box_suppression - greedy non-maximum suppression over box sets
// Ranks a set of boxes by score and keeps those not overlapping a better one.
// ----------------------------------------------------------------------------
// Usage:
//   Pulse start with a box on the req_ ports while busy is low; one box is
//   taken per accepted transaction. req_last_box closes the set.
//   Closing a set starts the ranking pass; the suppression pass follows,
//   testing each kept box against every later unsuppressed one.
//   csr_ writes the overlap threshold (Q1.8); the user must write it only
//   while idle, the block does not enforce it.
//   busy stays high until the last kept box has left.
//   Kept boxes leave in score order, one per rsp_valid pulse; the receiver
//   cannot stall, rsp_last_kept marks the final one and rsp_overflowed is
//   set on every result of a set that lost boxes beyond MAX_BOXES.
//   Reset clears the set, the flags and sets the threshold to 154.
// ----------------------------------------------------------------------------
module greedy_box_suppression #(
   parameter int MAX_BOXES   = gbs_pkg::MaxBoxesDefault,
   parameter int COORD_WIDTH = gbs_pkg::CoordWidthDefault
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [COORD_WIDTH-1:0]       req_x_min,
   input  logic signed [COORD_WIDTH-1:0]       req_y_min,
   input  logic signed [COORD_WIDTH-1:0]       req_x_max,
   input  logic signed [COORD_WIDTH-1:0]       req_y_max,
   input  logic [gbs_pkg::ScoreWidth-1:0]      req_score,
   input  logic                                req_last_box,
   output logic                                rsp_valid,
   output logic signed [COORD_WIDTH-1:0]       rsp_kept_x_min,
   output logic signed [COORD_WIDTH-1:0]       rsp_kept_y_min,
   output logic signed [COORD_WIDTH-1:0]       rsp_kept_x_max,
   output logic signed [COORD_WIDTH-1:0]       rsp_kept_y_max,
   output logic [gbs_pkg::ScoreWidth-1:0]      rsp_kept_score,
   output logic                                rsp_last_kept,
   output logic                                rsp_overflowed,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [gbs_pkg::ThrWidth-1:0]        csr_data
);

   localparam int IdxW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
   localparam int CntW = $clog2(MAX_BOXES + 1);

   logic [gbs_pkg::ThrWidth-1:0] thr_ff;
   logic front_busy, set_valid, set_overflow, set_taken;
   logic [CntW-1:0] set_count;
   logic [IdxW-1:0] rank_addr, rank_data, addr_a, addr_b;
   logic [4*COORD_WIDTH-1:0] corner_a, corner_b, out_c;
   logic [gbs_pkg::ScoreWidth-1:0] score_a;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= gbs_pkg::ThrReset;
      end else if (csr_valid && csr_ready) begin
         thr_ff <= csr_data;
      end
   end

   assign busy = front_busy;

   gbs_front #(.MAX_BOXES(MAX_BOXES), .COORD_WIDTH(COORD_WIDTH)) u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (start),
      .in_corners   ({req_y_max, req_x_max, req_y_min, req_x_min}),
      .in_score     (req_score),
      .in_last      (req_last_box),
      .in_busy      (front_busy),
      .set_valid    (set_valid),
      .set_count    (set_count),
      .set_overflow (set_overflow),
      .set_taken    (set_taken),
      .rank_addr    (rank_addr),
      .rank_data    (rank_data),
      .box_addr_a   (addr_a),
      .box_corner_a (corner_a),
      .box_score_a  (score_a),
      .box_addr_b   (addr_b),
      .box_corner_b (corner_b)
   );

   gbs_back #(.MAX_BOXES(MAX_BOXES), .COORD_WIDTH(COORD_WIDTH)) u_back (
      .clock        (clock),
      .reset        (reset),
      .threshold    (thr_ff),
      .set_valid    (set_valid),
      .set_count    (set_count),
      .set_overflow (set_overflow),
      .set_taken    (set_taken),
      .rank_addr    (rank_addr),
      .rank_data    (rank_data),
      .box_addr_a   (addr_a),
      .box_corner_a (corner_a),
      .box_score_a  (score_a),
      .box_addr_b   (addr_b),
      .box_corner_b (corner_b),
      .out_valid    (rsp_valid),
      .out_corners  (out_c),
      .out_score    (rsp_kept_score),
      .out_last     (rsp_last_kept),
      .out_overflow (rsp_overflowed)
   );

   assign {rsp_kept_y_max, rsp_kept_x_max, rsp_kept_y_min, rsp_kept_x_min} = out_c;

   // results only while a set is being worked off
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> busy)
      else $error("result outside a set");
   // a set closes through the last result before new intake
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_kept) |=> !busy)
      else $error("busy after last result");

endmodule

[dv/gbs_checker.sv]
// ----------------------------------------------------------------------------
// gbs_checker - scoreboard for greedy box suppression
// Watches box intake, threshold writes and kept-box results. It predicts the
// kept boxes of each set and compares them with what the block emits.
// ----------------------------------------------------------------------------
module gbs_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           busy,
   input  logic signed [15:0]             req_x_min,
   input  logic signed [15:0]             req_y_min,
   input  logic signed [15:0]             req_x_max,
   input  logic signed [15:0]             req_y_max,
   input  logic [gbs_pkg::ScoreWidth-1:0] req_score,
   input  logic                           req_last_box,
   input  logic                           rsp_valid,
   input  logic signed [15:0]             rsp_kept_x_min,
   input  logic signed [15:0]             rsp_kept_y_min,
   input  logic signed [15:0]             rsp_kept_x_max,
   input  logic signed [15:0]             rsp_kept_y_max,
   input  logic [gbs_pkg::ScoreWidth-1:0] rsp_kept_score,
   input  logic                           rsp_last_kept,
   input  logic                           rsp_overflowed,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [gbs_pkg::ThrWidth-1:0]   csr_data,
   output int                             errors,
   output int                             pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NB = gbs_pkg::MaxBoxesDefault;

   typedef struct packed {
      logic [15:0]                    x0;
      logic [15:0]                    y0;
      logic [15:0]                    x1;
      logic [15:0]                    y1;
      logic [gbs_pkg::ScoreWidth-1:0] score;
      logic                           last;
      logic                           ovf;
   } kept_box_type;

   kept_box_type                   kept_q[$];
   logic signed [15:0]             box_x0[NB];
   logic signed [15:0]             box_y0[NB];
   logic signed [15:0]             box_x1[NB];
   logic signed [15:0]             box_y1[NB];
   logic [gbs_pkg::ScoreWidth-1:0] box_score[NB];
   int                             box_n;
   bit                             dropped;
   logic [gbs_pkg::ThrWidth-1:0]   thr;

   function automatic longint span(longint lo, longint hi);
      return (hi > lo) ? hi - lo : 0;
   endfunction

   function automatic bit overlap_exceeds(int a, int b);
      longint inter, area_a, area_b, uni;
      inter  = span((box_x0[a] > box_x0[b]) ? box_x0[a] : box_x0[b],
                    (box_x1[a] < box_x1[b]) ? box_x1[a] : box_x1[b]) *
               span((box_y0[a] > box_y0[b]) ? box_y0[a] : box_y0[b],
                    (box_y1[a] < box_y1[b]) ? box_y1[a] : box_y1[b]);
      area_a = span(box_x0[a], box_x1[a]) * span(box_y0[a], box_y1[a]);
      area_b = span(box_x0[b], box_x1[b]) * span(box_y0[b], box_y1[b]);
      uni    = area_a + area_b - inter;
      return inter * 256 > longint'(thr) * uni;
   endfunction

   task automatic rank_and_suppress();
      int           rank[NB];
      bit           gone[NB];
      int           i, j, cur, n_kept;
      kept_box_type kb;
      n_kept = 0;
      // stable insertion sort, descending score
      for (i = 0; i < box_n; i++) begin
         cur = i;
         j = i;
         while (j > 0 && box_score[rank[j-1]] < box_score[cur]) begin
            rank[j] = rank[j-1];
            j--;
         end
         rank[j] = cur;
         gone[i] = 0;
      end
      for (i = 0; i < box_n; i++) begin
         if (!gone[i]) begin
            kb = '{box_x0[rank[i]], box_y0[rank[i]], box_x1[rank[i]], box_y1[rank[i]],
                   box_score[rank[i]], 1'b0, dropped};
            kept_q.insert(kept_q.size(), kb);
            n_kept++;
            for (j = i + 1; j < box_n; j++)
               if (!gone[j] && overlap_exceeds(rank[i], rank[j])) gone[j] = 1;
         end
      end
      if (n_kept > 0) kept_q[$].last = 1'b1;
      box_n = 0;
      dropped = 0;
   endtask

   always @(posedge clock) begin
      kept_box_type got, want;
      if (reset) begin
         box_n = 0;
         dropped = 0;
         thr = gbs_pkg::ThrReset;
         kept_q.delete();
         errors = 0;
      end else begin
         if (csr_valid && csr_ready) thr = csr_data;
         if (start && !busy) begin
            if (box_n < NB) begin
               box_x0[box_n] = req_x_min;
               box_y0[box_n] = req_y_min;
               box_x1[box_n] = req_x_max;
               box_y1[box_n] = req_y_max;
               box_score[box_n] = req_score;
               box_n++;
            end else begin
               dropped = 1;
            end
            if (req_last_box) rank_and_suppress();
         end
         if (rsp_valid) begin
            got = '{rsp_kept_x_min, rsp_kept_y_min, rsp_kept_x_max, rsp_kept_y_max,
                    rsp_kept_score, rsp_last_kept, rsp_overflowed};
            if (kept_q.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: kept box with none predicted: %h", $realtime, got);
            end else begin
               want = kept_q.pop_front();
               if (got.x0 !== want.x0 || got.y0 !== want.y0 || got.x1 !== want.x1 ||
                   got.y1 !== want.y1 || got.score !== want.score ||
                   got.last !== want.last || got.ovf !== want.ovf) begin
                  errors++;
                  if (errors <= 10)
                     $display({"%0t: kept box mismatch exp (%0d %0d %0d %0d s=%0d l=%0b o=%0b)",
                               " got (%0d %0d %0d %0d s=%0d l=%0b o=%0b)"}, $realtime,
                              $signed(want.x0), $signed(want.y0), $signed(want.x1),
                              $signed(want.y1), want.score, want.last, want.ovf,
                              $signed(got.x0), $signed(got.y0), $signed(got.x1),
                              $signed(got.y1), got.score, got.last, got.ovf);
               end
            end
         end
      end
      pending = kept_q.size();
   end

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb - regression bench for greedy box suppression
// Drives directed and random box sets with random gaps, rewrites the overlap
// threshold between sets, and reports the scoreboard verdict.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic                           clock, reset, start, busy;
   logic signed [15:0]             req_x_min, req_y_min, req_x_max, req_y_max;
   logic [gbs_pkg::ScoreWidth-1:0] req_score;
   logic                           req_last_box;
   logic                           rsp_valid;
   logic signed [15:0]             rsp_kept_x_min, rsp_kept_y_min, rsp_kept_x_max, rsp_kept_y_max;
   logic [gbs_pkg::ScoreWidth-1:0] rsp_kept_score;
   logic                           rsp_last_kept, rsp_overflowed;
   logic                           csr_valid, csr_ready;
   logic [gbs_pkg::ThrWidth-1:0]   csr_data;
   int                             errors, pending;
   bit                             no_gaps;

   greedy_box_suppression dut (.*);
   gbs_checker u_checker (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("greedy_box_suppression regression: fail");
      $finish;
   end

   task automatic idle_gap();
      int r, n;
      r = $urandom_range(0, 99);
      n = (no_gaps || r < 50) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      if (n > 0) begin
         @(negedge clock);
         start = 0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   // one box transaction; start stays high when no gap follows
   task automatic send_box(input logic [15:0] x0, y0, x1, y1, sc, input logic lst);
      @(negedge clock);
      start = 1;
      req_x_min = x0;
      req_y_min = y0;
      req_x_max = x1;
      req_y_max = y1;
      req_score = sc;
      req_last_box = lst;
      do @(posedge clock); while (busy);
      idle_gap();
   endtask

   task automatic drain_and_write(input logic [gbs_pkg::ThrWidth-1:0] value);
      @(negedge clock);
      start = 0;
      do @(posedge clock); while (pending != 0 || busy);
      repeat (20) @(posedge clock);
      @(negedge clock);
      csr_valid = 1;
      csr_data = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 0;
   endtask

   // overlapping clusters mostly; sometimes full-range corners
   task automatic random_box(input logic lst, input bit tie_scores);
      int cx, cy, w, h;
      logic [15:0] x0, y0, x1, y1, sc;
      if ($urandom_range(0, 9) == 0) begin
         x0 = 16'($urandom); y0 = 16'($urandom); x1 = 16'($urandom); y1 = 16'($urandom);
      end else begin
         cx = int'($urandom_range(0, 600)) - 300;
         cy = int'($urandom_range(0, 600)) - 300;
         w = int'($urandom_range(0, 900));
         h = int'($urandom_range(0, 900));
         if ($urandom_range(0, 19) == 0) w = -w;
         x0 = 16'(cx - w / 2); x1 = 16'(cx + w / 2);
         y0 = 16'(cy - h / 2); y1 = 16'(cy + h / 2);
      end
      sc = tie_scores ? 16'($urandom_range(0, 3) * 1000) : 16'($urandom);
      send_box(x0, y0, x1, y1, sc, lst);
   endtask

   task automatic mixed_set();
      send_box(16'sd100, 16'sd100, 16'sd500, 16'sd500, 16'd100, 1'b0);
      send_box(16'sd100, 16'sd100, 16'sd500, 16'sd500, 16'd100, 1'b0);
      send_box(16'sd120, 16'sd90, 16'sd520, 16'sd480, 16'd150, 1'b0);
      send_box(16'sd2000, 16'sd2000, 16'sd2100, 16'sd2100, 16'd200, 1'b0);
      send_box(16'sd600, 16'sd600, 16'sd100, 16'sd100, 16'd300, 1'b0);
      send_box(16'sd50, 16'sd50, 16'sd50, 16'sd50, 16'd100, 1'b1);
   endtask

   initial begin
      int set_len, k, items;
      bit ties;
      reset = 1; start = 0; csr_valid = 0; csr_data = '0; no_gaps = 0;
      req_x_min = '0; req_y_min = '0; req_x_max = '0; req_y_max = '0;
      req_score = '0; req_last_box = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: extremes, inverted single box, ties, degenerate pairs
      send_box(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'hffff, 1'b1);
      send_box(16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h0000, 1'b1);
      mixed_set();
      drain_and_write(9'd0);
      mixed_set();
      drain_and_write(9'd256);
      mixed_set();
      drain_and_write(9'd511);
      send_box(16'sd0, 16'sd0, 16'sd64, 16'sd64, 16'd7, 1'b0);
      send_box(16'sd0, 16'sd0, 16'sd64, 16'sd64, 16'd9, 1'b1);
      drain_and_write(gbs_pkg::ThrReset);

      items = 0;
      k = 0;
      while (items < 188) begin
         if (k == 6) begin
            // fill the store, then two dropped boxes, the last one closing the set
            for (int i = 0; i < 66; i++) random_box(i == 65, 0);
            items += 66;
         end else begin
            no_gaps = ($urandom_range(0, 4) == 0);
            ties = ($urandom_range(0, 2) == 0);
            set_len = $urandom_range(1, 8);
            for (int i = 0; i < set_len; i++) random_box(i == set_len - 1, ties);
            items += set_len;
            no_gaps = 0;
         end
         k++;
         if (k % 5 == 0) begin
            case ($urandom_range(0, 4))
               0: drain_and_write(9'd0);
               1: drain_and_write(9'd256);
               2: drain_and_write(9'd511);
               3: drain_and_write(gbs_pkg::ThrReset);
               default: drain_and_write(9'($urandom_range(0, 256)));
            endcase
         end
      end

      @(negedge clock);
      start = 0;
      do @(posedge clock); while (pending != 0);
      repeat (200) @(posedge clock);
      if (errors == 0)
         $display("greedy_box_suppression regression: pass");
      else
         $display("greedy_box_suppression regression: fail");
      $finish;
   end

endmodule
